// ----- src/crop_zoom_two_times_interpolate_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the crop and 2x zoom block
// Shared concurrent checks, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CROP_ZOOM_TWO_TIMES_INTERPOLATE_ASSERT_SVH
`define CROP_ZOOM_TWO_TIMES_INTERPOLATE_ASSERT_SVH

// Condition holds at every edge out of reset
`define CZI_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define CZI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define CZI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/czi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czi_pkg
// Types, codes and helpers shared by the crop and 2x zoom modules.
// ----------------------------------------------------------------------------
`default_nettype none

package czi_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_CROP_TOP    = 2'd1;
  localparam logic [1:0] CFG_CROP_LEFT   = 2'd2;
  localparam logic [1:0] CFG_CROP_SIZE   = 2'd3;

  // Result steps of one crop pixel, in emission order
  localparam logic [1:0] STEP_CTR  = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_LEFT = 2'd2;
  localparam logic [1:0] STEP_PIX  = 2'd3;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [10:0] image_width;
    logic [9:0]  crop_top;
    logic [9:0]  crop_left;
    logic [8:0]  crop_size;
  } czi_cfg_t;

  // One classified crop pixel with its neighbor means
  typedef struct packed {
    logic [8:0] orow;      // even output row 2r
    logic [8:0] ocol;      // even output column 2c
    logic [7:0] pix;
    logic [7:0] hm_top;    // mean of above-left and above
    logic [7:0] hm_bot;    // mean of left and pixel
    logic [7:0] vm;        // mean of above and pixel
    logic       has_up;
    logic       has_left;
    logic       last;
  } czi_entry_t;

  // Round-half-up mean of two 8-bit values
  function automatic logic [7:0] mean2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

endpackage

`default_nettype wire

// ----- src/czi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czi_front
// Tracks the image position, classifies pixels against the crop window,
// keeps the previous crop row and forms the neighbor means of each crop pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module czi_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_CROP  = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire czi_pkg::czi_cfg_t   cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_pixel,
  input  wire logic                in_frame_start,
  output logic                     push,
  output czi_pkg::czi_entry_t      push_entry,
  input  wire logic                q_ready
);
  import czi_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > 11) ? WW : 11;
  localparam int AW   = $clog2(MAX_CROP);

  logic [9:0]      row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [7:0]      left_r;
  logic [7:0]      above_left_r;
  logic [7:0]      mem [MAX_CROP];
  logic [7:0]      rd_r;

  logic            s1_valid_r, s1_valid_nxt;
  logic [7:0]      s1_pix_r;
  logic [7:0]      s1_left_r;
  logic [8:0]      s1_orow_r;
  logic [8:0]      s1_ocol_r;
  logic            s1_has_up_r;
  logic            s1_has_left_r;
  logic            s1_last_r;

  logic            accept;
  logic            crop_hit;
  logic            s1_move;
  logic [9:0]      row_cur;
  logic [CW-1:0]   col_cur;
  logic [CMPW-1:0] width_eff;
  logic [CMPW-1:0] size_eff;
  logic [CMPW-1:0] col_inc;
  logic [CMPW-1:0] row_ext;
  logic [CMPW-1:0] col_ext;
  logic [CMPW-1:0] top_ext;
  logic [CMPW-1:0] left_ext;
  logic [CMPW-1:0] r_ext;
  logic [CMPW-1:0] c_ext;
  logic            in_crop;
  logic [AW-1:0]   addr;

  // Clamp the configured width and crop size to their legal ranges
  always_comb begin
    width_eff = CMPW'(cfg.image_width);
    if (width_eff == '0) begin
      width_eff = CMPW'(1);
    end else if (width_eff > CMPW'(MAX_WIDTH)) begin
      width_eff = CMPW'(MAX_WIDTH);
    end
    size_eff = CMPW'(cfg.crop_size);
    if (size_eff == '0) begin
      size_eff = CMPW'(1);
    end else if (size_eff > CMPW'(MAX_CROP)) begin
      size_eff = CMPW'(MAX_CROP);
    end
  end

  // Advance the raster position
  assign accept  = in_valid && in_ready;
  assign row_cur = in_frame_start ? '0 : row_r;
  assign col_cur = in_frame_start ? '0 : col_r;
  assign col_inc = CMPW'(col_cur) + CMPW'(1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (col_inc >= width_eff) begin
        col_nxt = '0;
        row_nxt = row_cur + 10'd1;
      end else begin
        col_nxt = col_inc[CW-1:0];
        row_nxt = row_cur;
      end
    end
  end

  // Classify against the crop window
  assign row_ext  = CMPW'(row_cur);
  assign col_ext  = CMPW'(col_cur);
  assign top_ext  = CMPW'(cfg.crop_top);
  assign left_ext = CMPW'(cfg.crop_left);
  assign r_ext    = row_ext - top_ext;
  assign c_ext    = col_ext - left_ext;
  assign in_crop  = (row_ext >= top_ext) && (col_ext >= left_ext) &&
                    (r_ext < size_eff) && (c_ext < size_eff);
  assign crop_hit = accept && in_crop;
  assign addr     = c_ext[AW-1:0];

  // Row store: read the pixel above, then overwrite it with this one
  always_ff @(posedge clk) begin
    if (crop_hit) begin
      mem[addr] <= in_pixel;
      rd_r      <= mem[addr];
    end
  end

  // Stage 1 waits for room in the queue
  assign s1_move  = s1_valid_r && q_ready;
  assign in_ready = !s1_valid_r || q_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (crop_hit) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      left_r       <= '0;
      above_left_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (crop_hit) begin
        left_r <= in_pixel;
      end
      if (s1_move) begin
        above_left_r <= rd_r;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (crop_hit) begin
      s1_pix_r      <= in_pixel;
      s1_left_r     <= left_r;
      s1_orow_r     <= {r_ext[7:0], 1'b0};
      s1_ocol_r     <= {c_ext[7:0], 1'b0};
      s1_has_up_r   <= (r_ext != '0);
      s1_has_left_r <= (c_ext != '0);
      s1_last_r     <= (r_ext == size_eff - CMPW'(1)) && (c_ext == size_eff - CMPW'(1));
    end
  end

  // Form the queue entry with the neighbor means
  assign push = s1_move;

  always_comb begin
    push_entry.orow     = s1_orow_r;
    push_entry.ocol     = s1_ocol_r;
    push_entry.pix      = s1_pix_r;
    push_entry.hm_top   = mean2(above_left_r, rd_r);
    push_entry.hm_bot   = mean2(s1_left_r, s1_pix_r);
    push_entry.vm       = mean2(rd_r, s1_pix_r);
    push_entry.has_up   = s1_has_up_r;
    push_entry.has_left = s1_has_left_r;
    push_entry.last     = s1_last_r;
  end

endmodule

`default_nettype wire

// ----- src/czi_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czi_queue
// Short queue of classified crop pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module czi_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire czi_pkg::czi_entry_t  push_entry,
  output logic                      q_ready,
  input  wire logic                 pop,
  output logic                      q_valid,
  output czi_pkg::czi_entry_t       q_head
);
  import czi_pkg::*;

  `include "crop_zoom_two_times_interpolate_assert.svh"

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam logic [QAW:0]   FULL_CNT = (QAW + 1)'(QDEPTH);
  localparam logic [QAW-1:0] LAST_PTR = QAW'(QDEPTH - 1);

  czi_entry_t     slots [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign q_ready = (count_r != FULL_CNT);
  assign q_valid = (count_r != '0);
  assign q_head  = slots[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QAW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QAW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  `CZI_ASSERT_IMPL(a_no_overflow, push, count_r != FULL_CNT, "push into full queue")
  `CZI_ASSERT_IMPL(a_no_underflow, pop, count_r != '0, "pop from empty queue")

endmodule

`default_nettype wire

// ----- src/czi_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czi_back
// Expands each queued crop pixel into its zoom results, one per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module czi_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire czi_pkg::czi_entry_t  q_head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [8:0]                out_row,
  output logic [8:0]                out_col,
  output logic [7:0]                out_value,
  output logic                      out_run_last,
  output logic                      out_zoom_done
);
  import czi_pkg::*;

  `include "crop_zoom_two_times_interpolate_assert.svh"

  logic [3:0] taken_r, taken_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [8:0] out_row_r;
  logic [8:0] out_col_r;
  logic [7:0] out_value_r;
  logic       out_run_last_r;
  logic       out_zoom_done_r;

  logic [3:0] mask;
  logic [3:0] pend;
  logic [1:0] step;
  logic       load;
  logic [8:0] row_sel;
  logic [8:0] col_sel;
  logic [7:0] value_sel;
  logic       run_last_sel;
  logic       done_sel;

  // Results present for the head pixel, minus those already sent
  always_comb begin
    mask            = '0;
    mask[STEP_CTR]  = q_head.has_up && q_head.has_left;
    mask[STEP_UP]   = q_head.has_up;
    mask[STEP_LEFT] = q_head.has_left;
    mask[STEP_PIX]  = 1'b1;
    pend            = mask & ~taken_r;
  end

  // Pick the next result in raster order
  always_comb begin
    if (pend[STEP_CTR]) begin
      step = STEP_CTR;
    end else if (pend[STEP_UP]) begin
      step = STEP_UP;
    end else if (pend[STEP_LEFT]) begin
      step = STEP_LEFT;
    end else begin
      step = STEP_PIX;
    end
  end

  // Decode the chosen result
  always_comb begin
    row_sel      = q_head.orow;
    col_sel      = q_head.ocol;
    value_sel    = q_head.pix;
    run_last_sel = 1'b0;
    done_sel     = 1'b0;
    unique case (step)
      STEP_CTR: begin
        row_sel   = q_head.orow - 9'd1;
        col_sel   = q_head.ocol - 9'd1;
        value_sel = mean2(q_head.hm_top, q_head.hm_bot);
      end
      STEP_UP: begin
        row_sel   = q_head.orow - 9'd1;
        value_sel = q_head.vm;
      end
      STEP_LEFT: begin
        col_sel   = q_head.ocol - 9'd1;
        value_sel = q_head.hm_bot;
      end
      STEP_PIX: begin
        run_last_sel = 1'b1;
        done_sel     = q_head.last;
      end
      default: begin
        run_last_sel = 1'b0;
      end
    endcase
  end

  // Load the output register from the queue when it is free or being drained
  assign load = q_valid && (!out_valid_r || out_ready);
  assign pop  = load && (step == STEP_PIX);

  always_comb begin
    taken_nxt = taken_r;
    if (pop) begin
      taken_nxt = '0;
    end else if (load) begin
      taken_nxt = taken_r | (4'd1 << step);
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r       <= row_sel;
      out_col_r       <= col_sel;
      out_value_r     <= value_sel;
      out_run_last_r  <= run_last_sel;
      out_zoom_done_r <= done_sel;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_run_last  = out_run_last_r;
  assign out_zoom_done = out_zoom_done_r;

  `CZI_ASSERT_NEXT(a_pop_marks_last, pop, out_valid_r && out_run_last_r, "pop without run end")
  `CZI_ASSERT_IMPL(a_done_on_last, out_valid_r && out_zoom_done_r, out_run_last_r, "done off run end")
  `CZI_ASSERT_HOLDS(a_pix_never_kept, !taken_r[STEP_PIX], "pixel step left pending")

endmodule

`default_nettype wire

// ----- src/crop_zoom_two_times_interpolate.sv -----
`timescale 1ns / 1ps
// A crop pixel's results pass through stage 1, the queue and the output register.
// Pixels outside the crop window are taken one per cycle while in_ready is high; on the single
//   result port a crop pixel gives 4 results inside, 2 on top row or left column, 1 at corner.
// Reset: clears position counters, neighbor registers, queue and output valid; registers
//   return to width 1, top 0, left 0, size 1. The crop row store is not cleared.
// ----------------------------------------------------------------------------
// crop_zoom_two_times_interpolate
// Crops a square window from a raster grey image and emits its 2x bilinear zoom.
// ----------------------------------------------------------------------------
`default_nettype none

module crop_zoom_two_times_interpolate #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_CROP  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_pixel,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [8:0]       out_row,
  output logic [8:0]       out_col,
  output logic [7:0]       out_value,
  output logic             out_run_last,
  output logic             out_zoom_done,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import czi_pkg::*;

  czi_cfg_t   cfg_r;
  czi_entry_t push_entry;
  czi_entry_t q_head;
  logic       push;
  logic       q_ready;
  logic       q_valid;
  logic       pop;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width <= 11'd1;
      cfg_r.crop_top    <= '0;
      cfg_r.crop_left   <= '0;
      cfg_r.crop_size   <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: cfg_r.image_width <= cfg_data;
        CFG_CROP_TOP:    cfg_r.crop_top    <= cfg_data[9:0];
        CFG_CROP_LEFT:   cfg_r.crop_left   <= cfg_data[9:0];
        CFG_CROP_SIZE:   cfg_r.crop_size   <= cfg_data[8:0];
        default:         cfg_r.crop_size   <= cfg_r.crop_size;
      endcase
    end
  end

  czi_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_CROP  (MAX_CROP)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .push           (push),
    .push_entry     (push_entry),
    .q_ready        (q_ready)
  );

  czi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_head     (q_head)
  );

  czi_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_run_last  (out_run_last),
    .out_zoom_done (out_zoom_done)
  );

endmodule

`default_nettype wire
